### src/pcfl_pkg.sv
// Shared types and codes for the per-CPU page free-list allocator.
`timescale 1ns / 1ps

package pcfl_pkg;

  localparam int unsigned ADDR_W    = 56;
  localparam int unsigned CPU_IN_W  = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [ADDR_W-1:0] MEM_START_RST = 56'h00_0000_8000_0000;
  localparam logic [ADDR_W-1:0] MEM_STOP_RST  = 56'h00_0000_8800_0000;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MEM_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_STOP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LINK
  } state_e;

endpackage

### src/pcfl_link_ram.sv
// Link store: successor slot and successor-valid flag for every page slot.
`timescale 1ns / 1ps

module pcfl_link_ram #(
  parameter int unsigned DEPTH  = 32768,
  parameter int unsigned DATA_W = 16
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/pcfl_head_store.sv
// List heads: head slot RAM per CPU, valid flags in flops, lowest non-empty search.
`timescale 1ns / 1ps

module pcfl_head_store #(
  parameter int unsigned NUM_CPUS = 8,
  parameter int unsigned SLOT_W   = 15,
  parameter int unsigned CPU_W    = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [CPU_W-1:0]    rd_idx_i,
  output logic [SLOT_W-1:0]   rd_slot_o,
  input  logic                wr_en_i,
  input  logic [CPU_W-1:0]    wr_idx_i,
  input  logic [SLOT_W-1:0]   wr_slot_i,
  input  logic                wr_valid_i,
  output logic [NUM_CPUS-1:0] valid_o,
  output logic                any_o,
  output logic [CPU_W-1:0]    lowest_o
);

  logic [SLOT_W-1:0]   mem [NUM_CPUS];
  logic [SLOT_W-1:0]   rd_slot_q;
  logic [NUM_CPUS-1:0] valid_q;
  logic [NUM_CPUS-1:0] valid_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_slot_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_slot_q <= mem[rd_idx_i];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (wr_en_i) begin
      valid_d[wr_idx_i] = wr_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_comb begin
    lowest_o = '0;
    for (int i = NUM_CPUS - 1; i >= 0; i--) begin
      if (valid_q[i]) begin
        lowest_o = CPU_W'(i);
      end
    end
  end

  assign any_o     = |valid_q;
  assign valid_o   = valid_q;
  assign rd_slot_o = rd_slot_q;

endmodule

### src/per_cpu_page_free_list_allocator_unit.sv
// Per-CPU page free-list allocator with stealing: control, checks and result register.
`timescale 1ns / 1ps

// One request at a time. A free reads the head RAM in the accepting cycle (IDLE), then
// writes back link and head and gives its result (EXEC); an allocate reads the head RAM
// (IDLE), the link RAM (EXEC), then writes back the head and gives its result (LINK), or
// gives it in EXEC when every list is empty. The two RAM reads in series make the allocate
// the longer operation. A new request is taken at the earliest in the cycle after the result
// is produced, and only once that result leaves the output register, at the latest in the
// same cycle. An allocate on an empty list steals from the lowest-numbered non-empty list.
// The link store needs no clearing after reset: a link is only read for a page that a free
// placed on a list.
module per_cpu_page_free_list_allocator_unit
  import pcfl_pkg::*;
#(
  parameter int unsigned NUM_CPUS   = 8,
  parameter int unsigned NUM_PAGES  = 32768,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic [CPU_IN_W-1:0]  cpu_i,
  input  logic [ADDR_W-1:0]    page_address_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ADDR_W-1:0]    granted_address_o,
  output logic [1:0]           status_o
);

  localparam int unsigned CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int unsigned SLOT_W = $clog2(NUM_PAGES);
  localparam int unsigned PG_W   = ADDR_W - PAGE_SHIFT;

  state_e state_q, state_d;

  logic [ADDR_W-1:0] start_q, stop_q;

  logic              op_q;
  logic [CPU_W-1:0]  cpu_q;
  logic [CPU_W-1:0]  tgt_q;
  logic              got_q;
  logic [ADDR_W-1:0] pa_q;
  logic [SLOT_W-1:0] slot_q;

  logic              out_valid_q;
  logic [ADDR_W-1:0] out_addr_q;
  status_e           out_status_q;

  logic                in_fire;
  logic [CPU_IN_W-1:0] cpu_red;
  logic [CPU_W-1:0]    cpu_mod;
  logic [CPU_W-1:0]    tgt_sel;

  logic                head_rd_en;
  logic [SLOT_W-1:0]   head_rd_slot;
  logic                head_wr_en;
  logic [CPU_W-1:0]    head_wr_idx;
  logic [SLOT_W-1:0]   head_wr_slot;
  logic                head_wr_valid;
  logic [NUM_CPUS-1:0] head_valid;
  logic                head_any;
  logic [CPU_W-1:0]    head_lowest;

  logic              link_rd_en;
  logic [SLOT_W:0]   link_rd_data;
  logic              link_wr_en;
  logic [SLOT_W-1:0] link_wr_addr;
  logic [SLOT_W:0]   link_wr_data;

  logic              free_aligned, free_ge, free_lt, free_fits, free_ok;
  logic [PG_W-1:0]   base_page;
  logic [PG_W-1:0]   free_slot;
  logic [PG_W-1:0]   alloc_page;

  logic              fin;
  logic [ADDR_W-1:0] res_addr;
  status_e           res_status;

  // ---------------------------------------------------------------------------
  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= MEM_START_RST;
      stop_q  <= MEM_STOP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MEM_START: start_q <= cfg_data_i;
        REG_MEM_STOP:  stop_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request decode at acceptance
  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    cpu_red = cpu_i;
    for (int k = 0; k < 7; k++) begin
      if (32'(cpu_red) >= 32'(NUM_CPUS)) begin
        cpu_red = cpu_red - CPU_IN_W'(NUM_CPUS);
      end
    end
  end

  assign cpu_mod = CPU_W'(cpu_red);

  // own list first; if it is empty the lowest non-empty list is by definition another CPU's
  assign tgt_sel = (operation_i == OP_FREE || head_valid[cpu_mod]) ? cpu_mod : head_lowest;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= operation_i;
      cpu_q <= cpu_mod;
      tgt_q <= tgt_sel;
      got_q <= head_any;
      pa_q  <= page_address_i;
    end
    if (state_q == S_EXEC) begin
      slot_q <= head_rd_slot;
    end
  end

  // ---------------------------------------------------------------------------
  // Free address checks
  assign base_page    = start_q[ADDR_W-1:PAGE_SHIFT];
  assign free_aligned = (pa_q[PAGE_SHIFT-1:0] == '0);
  assign free_ge      = (pa_q >= start_q);
  assign free_lt      = (pa_q < stop_q);
  assign free_slot    = pa_q[ADDR_W-1:PAGE_SHIFT] - base_page;
  assign free_fits    = (free_slot < PG_W'(NUM_PAGES));
  assign free_ok      = free_aligned && free_ge && free_lt && free_fits;

  assign alloc_page   = PG_W'(slot_q) + base_page;

  // ---------------------------------------------------------------------------
  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (op_q == OP_ALLOC && got_q) state_d = S_LINK;
        else                           state_d = S_IDLE;
      end
      S_LINK: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // RAM writes happen only in EXEC/LINK and reads of the heads only in IDLE,
  // so read and write of one entry never overlap.
  always_comb begin
    in_ready_o    = 1'b0;
    head_rd_en    = 1'b0;
    head_wr_en    = 1'b0;
    head_wr_idx   = cpu_q;
    head_wr_slot  = free_slot[SLOT_W-1:0];
    head_wr_valid = 1'b1;
    link_rd_en    = 1'b0;
    link_wr_en    = 1'b0;
    link_wr_addr  = free_slot[SLOT_W-1:0];
    link_wr_data  = {head_valid[cpu_q], head_rd_slot};
    fin           = 1'b0;
    res_addr      = '0;
    res_status    = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        head_rd_en = in_fire;
      end
      S_EXEC: begin
        if (op_q == OP_FREE) begin
          fin        = 1'b1;
          head_wr_en = free_ok;
          link_wr_en = free_ok;
          res_status = free_ok ? ST_OK : ST_BAD_FREE;
        end else if (got_q) begin
          link_rd_en = 1'b1;
        end else begin
          fin        = 1'b1;
          res_status = ST_EMPTY;
        end
      end
      S_LINK: begin
        fin           = 1'b1;
        head_wr_en    = 1'b1;
        head_wr_idx   = tgt_q;
        head_wr_slot  = link_rd_data[SLOT_W-1:0];
        head_wr_valid = link_rd_data[SLOT_W];
        res_addr      = {alloc_page, {PAGE_SHIFT{1'b0}}};
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_addr_q   <= res_addr;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign granted_address_o = out_addr_q;
  assign status_o          = out_status_q;

  // ---------------------------------------------------------------------------
  pcfl_head_store #(
    .NUM_CPUS (NUM_CPUS),
    .SLOT_W   (SLOT_W),
    .CPU_W    (CPU_W)
  ) u_heads (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (head_rd_en),
    .rd_idx_i   (tgt_sel),
    .rd_slot_o  (head_rd_slot),
    .wr_en_i    (head_wr_en),
    .wr_idx_i   (head_wr_idx),
    .wr_slot_i  (head_wr_slot),
    .wr_valid_i (head_wr_valid),
    .valid_o    (head_valid),
    .any_o      (head_any),
    .lowest_o   (head_lowest)
  );

  pcfl_link_ram #(
    .DEPTH  (NUM_PAGES),
    .DATA_W (SLOT_W + 1)
  ) u_links (
    .clk_i     (clk_i),
    .rd_en_i   (link_rd_en),
    .rd_addr_i (head_rd_slot),
    .rd_data_o (link_rd_data),
    .wr_en_i   (link_wr_en),
    .wr_addr_i (link_wr_addr),
    .wr_data_i (link_wr_data)
  );

`ifndef NO_ASSERTIONS
  // a new result never lands on one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> !out_valid_q)
    else $error("result produced while output still held");

  // a push leaves that CPU's list non-empty
  a_push_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_wr_en && head_wr_valid) |=> head_valid[$past(head_wr_idx)])
    else $error("head valid not set after push");

  // bad-free status only ever comes from a free
  a_bad_free_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && res_status == ST_BAD_FREE) |-> (op_q == OP_FREE))
    else $error("bad-free status on an allocate");

  // link lookups only for an allocate that found a page
  a_link_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_rd_en |-> (op_q == OP_ALLOC && got_q) ##1 (state_q == S_LINK))
    else $error("unexpected link read");
`endif

endmodule

### bench/per_cpu_page_free_list_allocator_unit_tb.sv
// Self-checking bench for the per-CPU page free-list allocator: predictor, driver, monitor.
`timescale 1ns / 1ps

module per_cpu_page_free_list_allocator_unit_tb;
  import pcfl_pkg::*;

  localparam int unsigned NUM_CPUS    = 8;
  localparam int unsigned NUM_PAGES   = 32768;
  localparam int unsigned PAGE_SHIFT  = 12;
  localparam int unsigned SLOT_W      = $clog2(NUM_PAGES);
  localparam int unsigned PFN_W       = ADDR_W - PAGE_SHIFT;
  localparam int          CYCLE_LIMIT = 500_000;
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

  typedef struct packed {
    logic              op;
    logic [2:0]        cpu;
    logic [ADDR_W-1:0] addr;
  } page_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_e           status;
  } grant_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = REG_MEM_START;
  logic [ADDR_W-1:0]    cfg_data       = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic                 operation      = OP_ALLOC;
  logic [CPU_IN_W-1:0]  cpu            = '0;
  logic [ADDR_W-1:0]    page_address   = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [ADDR_W-1:0]    granted_address;
  logic [1:0]           status;

  per_cpu_page_free_list_allocator_unit #(
    .NUM_CPUS  (NUM_CPUS),
    .NUM_PAGES (NUM_PAGES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .operation_i      (operation),
    .cpu_i            (cpu),
    .page_address_i   (page_address),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .granted_address_o(granted_address),
    .status_o         (status)
  );

  always #5 clk_i = ~clk_i;

  // Allocator mirror: register copies, list heads and link store
  logic [ADDR_W-1:0] mdl_start = MEM_START_RST;
  logic [ADDR_W-1:0] mdl_stop  = MEM_STOP_RST;
  logic [SLOT_W-1:0] head_slot    [NUM_CPUS];
  bit                head_ok      [NUM_CPUS];
  logic [SLOT_W-1:0] page_link    [NUM_PAGES];
  bit                page_link_ok [NUM_PAGES];

  page_req_t pending_reqs[$];
  grant_t    expected_grants[$];
  page_req_t next_req;
  grant_t    want;
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;

  function automatic logic [SLOT_W-1:0] pop_page(int unsigned c);
    logic [SLOT_W-1:0] s;
    s            = head_slot[c];
    head_slot[c] = page_link[s];
    head_ok[c]   = page_link_ok[s];
    return s;
  endfunction

  function automatic grant_t predict_grant(logic op, logic [2:0] cpu_idx,
                                           logic [ADDR_W-1:0] pa);
    int unsigned       c;
    logic [PFN_W-1:0]  base;
    logic [PFN_W-1:0]  slot;
    logic [PFN_W-1:0]  pfn;
    logic [SLOT_W-1:0] s;
    logic              ok;
    logic              got;
    grant_t            g;
    c        = int'(cpu_idx) % NUM_CPUS;
    base     = mdl_start[ADDR_W-1:PAGE_SHIFT];
    g.addr   = '0;
    g.status = ST_OK;
    s        = '0;
    if (op == OP_FREE) begin
      ok   = (pa[PAGE_SHIFT-1:0] == '0) && (pa >= mdl_start) && (pa < mdl_stop);
      slot = pa[ADDR_W-1:PAGE_SHIFT] - base;
      if (ok && slot < NUM_PAGES) begin
        page_link[slot[SLOT_W-1:0]]    = head_slot[c];
        page_link_ok[slot[SLOT_W-1:0]] = head_ok[c];
        head_slot[c]                   = slot[SLOT_W-1:0];
        head_ok[c]                     = 1'b1;
      end else begin
        g.status = ST_BAD_FREE;
      end
    end else begin
      got = 1'b0;
      if (head_ok[c]) begin
        s   = pop_page(c);
        got = 1'b1;
      end
      // steal from the lowest-numbered other list
      for (int i = 0; i < NUM_CPUS; i++) begin
        if (!got && i != c && head_ok[i]) begin
          s   = pop_page(i);
          got = 1'b1;
        end
      end
      if (got) begin
        pfn    = base + PFN_W'(s);  // wraps at the address width
        g.addr = {pfn, {PAGE_SHIFT{1'b0}}};
      end else begin
        g.status = ST_EMPTY;
      end
    end
    return g;
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_grants.push_back(predict_grant(operation, cpu, page_address));
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req     = pending_reqs.pop_front();
          in_valid     <= 1'b1;
          operation    <= next_req.op;
          cpu          <= next_req.cpu;
          page_address <= next_req.addr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result beat with nothing pending: addr %h status %0d",
                     $realtime, granted_address, status);
          end
        end else begin
          want = expected_grants.pop_front();
          if (granted_address !== want.addr || status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: mismatch: addr exp %h got %h, status exp %0d got %0d",
                       $realtime, want.addr, granted_address, want.status, status);
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("per_cpu_page_free_list_allocator_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic push_req(logic op, logic [2:0] c, logic [ADDR_W-1:0] a);
    pending_reqs.push_back(page_req_t'{op: op, cpu: c, addr: a});
  endtask

  // wait until every request is answered and the write-back has settled
  task automatic drain();
    while (pending_reqs.size() != 0 || expected_grants.size() != 0 || in_valid) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_MEM_START) begin
      mdl_start = val;
    end else begin
      mdl_stop = val;
    end
    @(posedge clk_i);
  endtask

  task automatic set_range(logic [ADDR_W-1:0] lo_addr, logic [ADDR_W-1:0] hi_addr);
    drain();
    write_reg(REG_MEM_START, lo_addr);
    write_reg(REG_MEM_STOP, hi_addr);
  endtask

  // Mostly allocs and in-range frees so lists grow, drain and get stolen from
  task automatic queue_random(int unsigned n);
    logic [63:0]       lo_pg;
    logic [63:0]       hi_pg;
    logic [63:0]       top_pg;
    logic [63:0]       pg;
    logic [63:0]       rnd64;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        c;
    logic              have_range;
    int unsigned       span;
    int unsigned       near;
    int unsigned       pick;
    lo_pg  = ({8'd0, mdl_start} + 64'd4095) >> PAGE_SHIFT;
    top_pg = ({8'd0, mdl_start} >> PAGE_SHIFT) + NUM_PAGES - 1;
    hi_pg  = ({8'd0, mdl_stop} - 64'd1) >> PAGE_SHIFT;
    if (hi_pg > top_pg) hi_pg = top_pg;
    have_range = (mdl_stop > mdl_start) && (lo_pg <= hi_pg);
    span       = have_range ? int'(hi_pg - lo_pg) : 0;
    near       = (span < 63) ? span : 63;
    for (int i = 0; i < n; i++) begin
      pick  = $urandom_range(99);
      c     = 3'($urandom_range(7));
      rnd64 = {$urandom, $urandom};
      addr  = rnd64[ADDR_W-1:0];
      case ($urandom_range(2))
        0:       pg = lo_pg + 64'($urandom_range(near));
        1:       pg = hi_pg - 64'($urandom_range(near));
        default: pg = lo_pg + 64'($urandom_range(span));
      endcase
      if (pick < 45) begin
        push_req(OP_ALLOC, c, addr);
      end else if (pick < 85 && have_range) begin
        push_req(OP_FREE, c, ADDR_W'(pg << PAGE_SHIFT));
      end else begin
        case ($urandom_range(3))
          0: push_req(OP_FREE, c, addr);
          1: push_req(OP_FREE, c, ADDR_W'(pg << PAGE_SHIFT) | ADDR_W'($urandom_range(1, 4095)));
          2: push_req(OP_FREE, c, mdl_stop);
          default: push_req(OP_FREE, c,
                            ADDR_W'((({8'd0, mdl_start} >> PAGE_SHIFT) - 1) << PAGE_SHIFT));
        endcase
      end
    end
  endtask

  initial begin
    logic [63:0]       rnd64;
    logic [ADDR_W-1:0] lo_addr;
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed: edges of the range, bad frees, LIFO order, stealing, empty
    push_req(OP_ALLOC, 3'd0, '0);
    push_req(OP_FREE,  3'd0, 56'h00_0000_8000_0000);
    push_req(OP_FREE,  3'd0, 56'h00_0000_87FF_F000);
    push_req(OP_FREE,  3'd0, 56'h00_0000_8000_0800);
    push_req(OP_FREE,  3'd1, 56'h00_0000_7FFF_F000);
    push_req(OP_FREE,  3'd2, 56'h00_0000_8800_0000);
    push_req(OP_FREE,  3'd3, '0);
    push_req(OP_FREE,  3'd4, ADDR_ONES);
    push_req(OP_FREE,  3'd7, 56'h00_0000_8000_1000);
    push_req(OP_ALLOC, 3'd0, ADDR_ONES);
    push_req(OP_ALLOC, 3'd3, '0);
    push_req(OP_ALLOC, 3'd3, '0);
    push_req(OP_ALLOC, 3'd5, '0);
    push_req(OP_FREE,  3'd5, 56'h00_0000_8123_4000);
    push_req(OP_FREE,  3'd2, 56'h00_0000_8765_0000);
    push_req(OP_ALLOC, 3'd6, '0);
    push_req(OP_ALLOC, 3'd5, '0);

    // listed pages survive a move of the start; the rebuilt address wraps
    set_range(56'hFF_FFFF_F800_0000, ADDR_ONES);
    push_req(OP_FREE,  3'd1, 56'hFF_FFFF_FFFF_F000);
    push_req(OP_FREE,  3'd1, 56'hFF_FFFF_F800_0000);
    drain();
    write_reg(REG_MEM_START, 56'hFF_FFFF_FFFF_F000);
    push_req(OP_ALLOC, 3'd1, '0);
    push_req(OP_ALLOC, 3'd1, '0);

    // slot just past the link store
    set_range('0, ADDR_ONES);
    push_req(OP_FREE,  3'd6, 56'h00_0000_0800_0000);
    push_req(OP_FREE,  3'd6, 56'h00_0000_07FF_F000);
    push_req(OP_ALLOC, 3'd2, '0);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_range(MEM_START_RST, MEM_STOP_RST);
        1: set_range('0, ADDR_ONES);
        2: set_range(56'h00_1234_5678_9ABC, 56'h00_1234_5A00_0000);
        3: set_range(56'hFF_FFFF_F800_0000, ADDR_ONES);
        4: set_range(56'h00_0000_9000_0000, 56'h00_0000_8000_0000);
        5: begin
          rnd64   = {$urandom, $urandom};
          lo_addr = rnd64[ADDR_W-1:0] & 56'h7F_FFFF_FFFF_FFFF;
          set_range(lo_addr, lo_addr + ADDR_W'($urandom_range(1, 32'h0800_0000)));
        end
        6: set_range(56'h00_0000_4000_0000, 56'h00_0000_4000_0000);
        default: set_range(56'h00_0000_0001_0000, 56'h00_0000_0001_3000);
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      queue_random(228);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("per_cpu_page_free_list_allocator_unit_tb: PASS");
    end else begin
      $display("per_cpu_page_free_list_allocator_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
src/pcfl_pkg.sv
src/pcfl_link_ram.sv
src/pcfl_head_store.sv
src/per_cpu_page_free_list_allocator_unit.sv
bench/per_cpu_page_free_list_allocator_unit_tb.sv
